// ===== rtl/ri2a_pkg.sv =====
// Shared types, base codes and digit lookup for the radix integer to ASCII block.
package ri2a_pkg;

    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_DEC = 2'd2;
    localparam logic [1:0] BASE_HEX = 2'd3;

    localparam int DIGIT_BITS = 80;
    localparam int BCD_DIGITS = 20;

    localparam logic [6:0] NDIG_BIN = 7'd64;
    localparam logic [6:0] NDIG_OCT = 7'd22;
    localparam logic [6:0] NDIG_DEC = 7'd20;
    localparam logic [6:0] NDIG_HEX = 7'd16;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  base_select;
        logic        upper_case;
        logic [6:0]  min_width;
        logic        pad_zero;
        logic        align_left;
    } request_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } result_t;

    typedef struct packed {
        logic [DIGIT_BITS-1:0] digits;
        logic [1:0]            base_select;
        logic                  upper_case;
        logic [6:0]            count;
        logic [6:0]            width;
        logic [7:0]            pad_char;
    } emit_load_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10)
            c = CHAR_ZERO + {4'b0, d};
        else if (upper)
            c = CHAR_UPPER_A + {4'b0, d - 4'd10};
        else
            c = CHAR_LOWER_A + {4'b0, d - 4'd10};
        return c;
    endfunction

endpackage

// ===== rtl/ri2a_dabble.sv =====
// Bit-serial binary to BCD converter using shift and add-3.
module ri2a_dabble (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [63:0]                    value,
    output logic                           done,
    output logic [ri2a_pkg::DIGIT_BITS-1:0] bcd
);

    logic [63:0]                     bin_reg, bin_next;
    logic [ri2a_pkg::DIGIT_BITS-1:0] bcd_reg, bcd_next;
    logic [ri2a_pkg::DIGIT_BITS-1:0] adjusted;
    logic [5:0]                      cnt_reg, cnt_next;
    logic                            run_reg, run_next;
    logic                            done_reg, done_next;

    always_comb
    begin
        for (int i = 0; i < ri2a_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                adjusted[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                adjusted[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next = value;
            bcd_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            bcd_next = {adjusted[ri2a_pkg::DIGIT_BITS-2:0], bin_reg[63]};
            bin_next = {bin_reg[62:0], 1'b0};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// ===== rtl/ri2a_emit.sv =====
// Digit shifter that skips leading zeros, emits padding, then emits digits.
module ri2a_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  ri2a_pkg::emit_load_t cfg,
    output logic                 done,
    output logic                 strobe,
    output ri2a_pkg::result_t    result
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SKIP = 2'd1;
    localparam logic [1:0] PH_PAD  = 2'd2;
    localparam logic [1:0] PH_DIG  = 2'd3;

    logic [1:0]                      phase_reg, phase_next;
    logic [ri2a_pkg::DIGIT_BITS-1:0] digits_reg, digits_next;
    logic [6:0]                      count_reg, count_next;
    logic [6:0]                      pad_reg, pad_next;
    logic [6:0]                      width_reg, width_next;
    logic [1:0]                      base_reg, base_next;
    logic                            upper_reg, upper_next;
    logic [7:0]                      padc_reg, padc_next;
    logic                            strobe_reg, strobe_next;
    ri2a_pkg::result_t               result_reg, result_next;
    logic [3:0]                      top4;
    logic [3:0]                      digit;
    logic [ri2a_pkg::DIGIT_BITS-1:0] shifted;

    assign top4 = digits_reg[ri2a_pkg::DIGIT_BITS-1 -: 4];

    always_comb
    begin
        case (base_reg)
            ri2a_pkg::BASE_BIN:
            begin
                digit   = {3'b000, top4[3]};
                shifted = {digits_reg[ri2a_pkg::DIGIT_BITS-2:0], 1'b0};
            end
            ri2a_pkg::BASE_OCT:
            begin
                digit   = {1'b0, top4[3:1]};
                shifted = {digits_reg[ri2a_pkg::DIGIT_BITS-4:0], 3'b000};
            end
            default:
            begin
                digit   = top4;
                shifted = {digits_reg[ri2a_pkg::DIGIT_BITS-5:0], 4'b0000};
            end
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        digits_next = digits_reg;
        count_next  = count_reg;
        pad_next    = pad_reg;
        width_next  = width_reg;
        base_next   = base_reg;
        upper_next  = upper_reg;
        padc_next   = padc_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        done        = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (load)
                begin
                    digits_next = cfg.digits;
                    count_next  = cfg.count;
                    width_next  = cfg.width;
                    base_next   = cfg.base_select;
                    upper_next  = cfg.upper_case;
                    padc_next   = cfg.pad_char;
                    phase_next  = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (digit == 4'd0 && count_reg > 7'd1)
                begin
                    digits_next = shifted;
                    count_next  = count_reg - 7'd1;
                end
                else
                begin
                    pad_next   = (width_reg > count_reg) ? width_reg - count_reg : 7'd0;
                    phase_next = PH_PAD;
                end
            end
            PH_PAD:
            begin
                if (pad_reg != 7'd0)
                begin
                    strobe_next           = 1'b1;
                    result_next.out_char  = padc_reg;
                    result_next.last_char = 1'b0;
                    pad_next              = pad_reg - 7'd1;
                end
                else
                begin
                    phase_next = PH_DIG;
                end
            end
            PH_DIG:
            begin
                strobe_next           = 1'b1;
                result_next.out_char  = ri2a_pkg::digit_char(digit, upper_reg);
                result_next.last_char = (count_reg == 7'd1);
                digits_next           = shifted;
                count_next            = count_reg - 7'd1;
                if (count_reg == 7'd1)
                begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        count_reg  <= count_next;
        pad_reg    <= pad_next;
        width_reg  <= width_next;
        base_reg   <= base_next;
        upper_reg  <= upper_next;
        padc_reg   <= padc_next;
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// ===== rtl/radix_integer_to_ascii.sv =====
// Top level of the radix integer to ASCII converter.
// Usage:
//   Drive request and raise start; the request is taken on a rising edge
//   where start is high and busy is low. Busy falls in the cycle that puts
//   the last character of that value on result; a new request may be taken
//   at the edge that ends that cycle.
//   Each character appears on result for exactly one cycle with strobe
//   high; result.last_char marks the final digit. The receiver cannot stall.
//   Output order: padding ('0' or space), then digits most significant first.
// Steps per request:
//   binary, octal, hex: a prepare step, then leading zero digits are
//   skipped one per cycle (up to 63), then padding, then digits; decimal
//   first runs the bit-serial shift-and-add-3 BCD conversion. Padding
//   and digit characters leave one per cycle, with a pause after the
//   padding step. Worst case is a decimal zero with width 64.
// Reset:
//   rst_n clears all control state; the block comes up idle with busy low.
module radix_integer_to_ascii #(
    parameter int MAX_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ri2a_pkg::request_t request,
    output logic               strobe,
    output ri2a_pkg::result_t  result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_PREP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;
    localparam logic [6:0] WIDTH_CAP = 7'(MAX_WIDTH);

    logic [1:0]                      state_reg, state_next;
    ri2a_pkg::request_t              req_reg, req_next;
    logic                            accept;
    logic                            conv_start;
    logic                            conv_done;
    logic [ri2a_pkg::DIGIT_BITS-1:0] bcd;
    logic                            emit_load;
    logic                            emit_done;
    ri2a_pkg::emit_load_t            load_cfg;
    logic [6:0]                      width_sat;

    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);
    assign conv_start = accept && (request.base_select == ri2a_pkg::BASE_DEC);
    assign emit_load  = (state_reg == ST_PREP);

    always_comb
    begin
        width_sat = (req_reg.min_width > WIDTH_CAP) ? WIDTH_CAP : req_reg.min_width;
        load_cfg.base_select = req_reg.base_select;
        load_cfg.upper_case  = req_reg.upper_case;
        load_cfg.width       = req_reg.align_left ? 7'd0 : width_sat;
        load_cfg.pad_char    = req_reg.pad_zero ? ri2a_pkg::CHAR_ZERO : ri2a_pkg::CHAR_SPACE;
        case (req_reg.base_select)
            ri2a_pkg::BASE_BIN:
            begin
                load_cfg.digits = {req_reg.value, 16'h0000};
                load_cfg.count  = ri2a_pkg::NDIG_BIN;
            end
            ri2a_pkg::BASE_OCT:
            begin
                load_cfg.digits = {2'b00, req_reg.value, 14'h0000};
                load_cfg.count  = ri2a_pkg::NDIG_OCT;
            end
            ri2a_pkg::BASE_DEC:
            begin
                load_cfg.digits = bcd;
                load_cfg.count  = ri2a_pkg::NDIG_DEC;
            end
            default:
            begin
                load_cfg.digits = {req_reg.value, 16'h0000};
                load_cfg.count  = ri2a_pkg::NDIG_HEX;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next   = request;
                    state_next = (request.base_select == ri2a_pkg::BASE_DEC) ? ST_CONV : ST_PREP;
                end
            end
            ST_CONV:
            begin
                if (conv_done)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    ri2a_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .value (request.value),
        .done  (conv_done),
        .bcd   (bcd)
    );

    ri2a_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (emit_load),
        .cfg    (load_cfg),
        .done   (emit_done),
        .strobe (strobe),
        .result (result)
    );

endmodule
